[rtl/apls_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants of the ATA PIO LBA28 read sequencer.
// Used by apls_ctrl, apls_emit and the top level; no dependencies.
package apls_pkg;

  localparam int unsigned WordsPerSector = 256;

  localparam logic [19:0] SpinReset = 20'd100000;

  localparam logic [1:0] ReqStart  = 2'd0;
  localparam logic [1:0] ReqStatus = 2'd1;
  localparam logic [1:0] ReqData   = 2'd2;

  localparam logic [1:0] KindWrite   = 2'd0;
  localparam logic [1:0] KindReadReq = 2'd1;
  localparam logic [1:0] KindWord    = 2'd2;
  localparam logic [1:0] KindDone    = 2'd3;

  localparam logic [1:0] FailNone    = 2'd0;
  localparam logic [1:0] FailBadReq  = 2'd1;
  localparam logic [1:0] FailTimeout = 2'd2;
  localparam logic [1:0] FailDevice  = 2'd3;

  localparam logic [9:0] PortData   = 10'h1F0;
  localparam logic [9:0] PortCount  = 10'h1F2;
  localparam logic [9:0] PortLbaLo  = 10'h1F3;
  localparam logic [9:0] PortLbaMid = 10'h1F4;
  localparam logic [9:0] PortLbaHi  = 10'h1F5;
  localparam logic [9:0] PortDrive  = 10'h1F6;
  localparam logic [9:0] PortStatus = 10'h1F7;
  localparam logic [9:0] PortAlt    = 10'h3F6;
  localparam logic [9:0] PortWait   = 10'h080;

  localparam logic [7:0] CmdRead     = 8'h20;
  localparam logic [7:0] DhLbaMaster = 8'hE0;
  localparam logic [7:0] CtrlNien    = 8'h02;

  localparam int unsigned StErr = 0;
  localparam int unsigned StDrq = 3;
  localparam int unsigned StDf  = 5;
  localparam int unsigned StBsy = 7;

  localparam logic [3:0] CmdLastIdx = 4'd8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  port;
    logic [15:0] value;
    logic [15:0] word_index;
    logic        read_ok;
    logic [1:0]  fail_code;
  } res_t;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  last_idx;
    res_t        r0;
    res_t        r1;
    logic [27:0] lba;
    logic [7:0]  cnt;
    logic [28:0] last_block;
  } burst_t;

  function automatic res_t mk_res(input logic [1:0] kind, input logic [9:0] port,
                                  input logic [15:0] value);
    res_t r;
    r            = '0;
    r.kind       = kind;
    r.port       = port;
    r.value      = value;
    return r;
  endfunction

  function automatic res_t cmd_result(input logic [3:0] idx, input logic [27:0] lba,
                                      input logic [7:0] cnt);
    res_t r;
    case (idx)
      4'd0:    r = mk_res(KindWrite, PortAlt, {8'd0, CtrlNien});
      4'd1:    r = mk_res(KindWrite, PortDrive, {8'd0, DhLbaMaster | {4'd0, lba[27:24]}});
      4'd2:    r = mk_res(KindWrite, PortWait, 16'd0);
      4'd3:    r = mk_res(KindWrite, PortCount, {8'd0, cnt});
      4'd4:    r = mk_res(KindWrite, PortLbaLo, {8'd0, lba[7:0]});
      4'd5:    r = mk_res(KindWrite, PortLbaMid, {8'd0, lba[15:8]});
      4'd6:    r = mk_res(KindWrite, PortLbaHi, {8'd0, lba[23:16]});
      4'd7:    r = mk_res(KindWrite, PortStatus, {8'd0, CmdRead});
      4'd8:    r = mk_res(KindReadReq, PortStatus, 16'd0);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/ata_pio_lba28_read_sequencer_core.sv]
`timescale 1ns / 1ps
// Top level of the ATA PIO LBA28 read sequencer: apls_ctrl feeding apls_emit.
// Depends on apls_pkg, apls_ctrl and apls_emit.
//
//   channel | handshake               | payload
//   --------+-------------------------+----------------------------------------------
//   in      | in_valid_i / in_ready_o | req_type, start_lba, count, status_byte, data_word
//   out     | out_valid_o/out_ready_i | out_kind, port, value, word_index, read_ok,
//           |                         | fail_code, last_block, is_last
//   cfg     | cfg_valid_i/cfg_ready_o | cfg_spin_limit_i (always ready)
//
// A transaction is held in the input register, then its results leave the result
// register one per cycle while out_ready_i is high: one result for most transactions,
// two for a data word, nine for the command burst after busy clears. The result
// register sets the rate. Transactions that fit no phase are dropped, even in a stall.
// Reset leaves the block idle with spin limit 100000; an output stall otherwise holds both stages.
module ata_pio_lba28_read_sequencer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] start_lba_i,
  input  logic [7:0]  count_i,
  input  logic [7:0]  status_byte_i,
  input  logic [15:0] data_word_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [19:0] cfg_spin_limit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_kind_o,
  output logic [9:0]  port_o,
  output logic [15:0] value_o,
  output logic [15:0] word_index_o,
  output logic        read_ok_o,
  output logic [1:0]  fail_code_o,
  output logic [28:0] last_block_o,
  output logic        is_last_o
);

  logic             emit_free;
  logic             load;
  apls_pkg::burst_t burst;

  assign cfg_ready_o = 1'b1;

  apls_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .start_lba_i      (start_lba_i),
    .count_i          (count_i),
    .status_byte_i    (status_byte_i),
    .data_word_i      (data_word_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_spin_limit_i (cfg_spin_limit_i),
    .emit_free_i      (emit_free),
    .load_o           (load),
    .burst_o          (burst)
  );

  apls_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .burst_i      (burst),
    .emit_free_o  (emit_free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_kind_o   (out_kind_o),
    .port_o       (port_o),
    .value_o      (value_o),
    .word_index_o (word_index_o),
    .read_ok_o    (read_ok_o),
    .fail_code_o  (fail_code_o),
    .last_block_o (last_block_o),
    .is_last_o    (is_last_o)
  );

endmodule

[rtl/apls_ctrl.sv]
`timescale 1ns / 1ps
// Input register, sequencer state and per-transaction decision logic.
// Depends on apls_pkg; feeds a result burst descriptor to apls_emit.
module apls_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           req_type_i,
  input  logic [31:0]          start_lba_i,
  input  logic [7:0]           count_i,
  input  logic [7:0]           status_byte_i,
  input  logic [15:0]          data_word_i,
  input  logic                 cfg_valid_i,
  input  logic [19:0]          cfg_spin_limit_i,
  input  logic                 emit_free_i,
  output logic                 load_o,
  output apls_pkg::burst_t     burst_o
);

  localparam logic [1:0] PhIdle     = 2'd0;
  localparam logic [1:0] PhWaitBusy = 2'd1;
  localparam logic [1:0] PhWaitDrq  = 2'd2;
  localparam logic [1:0] PhData     = 2'd3;

  logic        hold_v_q;
  logic [1:0]  req_q;
  logic [31:0] lba_q;
  logic [7:0]  cnt_q;
  logic [7:0]  st_q;
  logic [15:0] dw_q;

  logic [1:0]  phase_q, phase_d;
  logic [19:0] spin_limit_q;
  logic [19:0] spin_q, spin_d;
  logic [27:0] base_q, base_d;
  logic [7:0]  total_q, total_d;
  logic [7:0]  sidx_q, sidx_d;
  logic [7:0]  widx_q, widx_d;
  logic [28:0] last_block_q, last_block_d;
  logic        ok_q, ok_d;

  logic        ignore;
  logic        consume;
  logic [20:0] spin_next;
  logic        timeout;
  logic [8:0]  word_next;
  logic [7:0]  sidx_next;
  logic [28:0] fail_blk;
  logic [28:0] done_blk;
  logic [15:0] word_pos;
  apls_pkg::burst_t burst;

  assign spin_next = {1'b0, spin_q} + 21'd1;
  assign timeout   = spin_next >= {1'b0, spin_limit_q};
  assign word_next = {1'b0, widx_q} + 9'd1;
  assign sidx_next = sidx_q + 8'd1;
  assign fail_blk  = {1'b0, base_q} + {21'd0, sidx_q};
  assign done_blk  = {1'b0, base_q} + {21'd0, total_q} - 29'd1;
  assign word_pos  = {8'd0, sidx_q} * 16'(apls_pkg::WordsPerSector) + {8'd0, widx_q};

  always_comb begin
    phase_d      = phase_q;
    spin_d       = spin_q;
    base_d       = base_q;
    total_d      = total_q;
    sidx_d       = sidx_q;
    widx_d       = widx_q;
    last_block_d = last_block_q;
    ok_d         = ok_q;
    ignore       = 1'b1;
    burst        = '0;
    case (phase_q)
      PhIdle: begin
        if (req_q == apls_pkg::ReqStart) begin
          ignore = 1'b0;
          if (cnt_q == 8'd0 || lba_q[31:28] != 4'd0) begin
            ok_d                = 1'b0;
            burst.r0            = apls_pkg::mk_res(apls_pkg::KindDone, 10'd0, 16'd0);
            burst.r0.fail_code  = apls_pkg::FailBadReq;
          end else begin
            base_d   = lba_q[27:0];
            total_d  = cnt_q;
            sidx_d   = 8'd0;
            widx_d   = 8'd0;
            spin_d   = 20'd0;
            phase_d  = PhWaitBusy;
            burst.r0 = apls_pkg::mk_res(apls_pkg::KindReadReq, apls_pkg::PortAlt, 16'd0);
          end
        end
      end
      PhWaitBusy: begin
        if (req_q == apls_pkg::ReqStatus) begin
          ignore = 1'b0;
          if (!st_q[apls_pkg::StBsy]) begin
            burst.cmd      = 1'b1;
            burst.last_idx = apls_pkg::CmdLastIdx;
            burst.lba      = base_q;
            burst.cnt      = total_q;
            spin_d         = 20'd0;
            phase_d        = PhWaitDrq;
          end else if (timeout) begin
            spin_d             = spin_next[19:0];
            ok_d               = 1'b0;
            phase_d            = PhIdle;
            burst.r0           = apls_pkg::mk_res(apls_pkg::KindDone, 10'd0, 16'd0);
            burst.r0.fail_code = apls_pkg::FailTimeout;
          end else begin
            spin_d   = spin_next[19:0];
            burst.r0 = apls_pkg::mk_res(apls_pkg::KindReadReq, apls_pkg::PortAlt, 16'd0);
          end
        end
      end
      PhWaitDrq: begin
        if (req_q == apls_pkg::ReqStatus) begin
          ignore = 1'b0;
          if (st_q[apls_pkg::StErr] || st_q[apls_pkg::StDf]) begin
            ok_d               = 1'b0;
            last_block_d       = fail_blk;
            phase_d            = PhIdle;
            burst.r0           = apls_pkg::mk_res(apls_pkg::KindDone, 10'd0, 16'd0);
            burst.r0.fail_code = apls_pkg::FailDevice;
          end else if (!st_q[apls_pkg::StBsy] && st_q[apls_pkg::StDrq]) begin
            widx_d   = 8'd0;
            phase_d  = PhData;
            burst.r0 = apls_pkg::mk_res(apls_pkg::KindReadReq, apls_pkg::PortData, 16'd0);
          end else if (timeout) begin
            spin_d             = spin_next[19:0];
            ok_d               = 1'b0;
            last_block_d       = fail_blk;
            phase_d            = PhIdle;
            burst.r0           = apls_pkg::mk_res(apls_pkg::KindDone, 10'd0, 16'd0);
            burst.r0.fail_code = apls_pkg::FailTimeout;
          end else begin
            spin_d   = spin_next[19:0];
            burst.r0 = apls_pkg::mk_res(apls_pkg::KindReadReq, apls_pkg::PortStatus, 16'd0);
          end
        end
      end
      PhData: begin
        if (req_q == apls_pkg::ReqData) begin
          ignore               = 1'b0;
          burst.last_idx       = 4'd1;
          burst.r0             = apls_pkg::mk_res(apls_pkg::KindWord, 10'd0, dw_q);
          burst.r0.word_index  = word_pos;
          if (word_next >= 9'(apls_pkg::WordsPerSector)) begin
            widx_d = 8'd0;
            sidx_d = sidx_next;
            if (sidx_next >= total_q) begin
              last_block_d     = done_blk;
              ok_d             = 1'b1;
              phase_d          = PhIdle;
              burst.r1         = apls_pkg::mk_res(apls_pkg::KindDone, 10'd0, 16'd0);
              burst.r1.read_ok = 1'b1;
            end else begin
              spin_d   = 20'd0;
              phase_d  = PhWaitDrq;
              burst.r1 = apls_pkg::mk_res(apls_pkg::KindReadReq, apls_pkg::PortStatus, 16'd0);
            end
          end else begin
            widx_d   = word_next[7:0];
            burst.r1 = apls_pkg::mk_res(apls_pkg::KindReadReq, apls_pkg::PortData, 16'd0);
          end
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
    burst.last_block = last_block_d;
  end

  assign consume    = hold_v_q && (ignore || emit_free_i);
  assign load_o     = hold_v_q && !ignore && emit_free_i;
  assign burst_o    = burst;
  assign in_ready_o = !hold_v_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q     <= 1'b0;
      phase_q      <= PhIdle;
      spin_limit_q <= apls_pkg::SpinReset;
      spin_q       <= 20'd0;
      base_q       <= 28'd0;
      total_q      <= 8'd0;
      sidx_q       <= 8'd0;
      widx_q       <= 8'd0;
      last_block_q <= 29'd0;
      ok_q         <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        spin_limit_q <= cfg_spin_limit_i;
      end
      if (in_ready_o) begin
        hold_v_q <= in_valid_i;
      end
      if (consume) begin
        phase_q      <= phase_d;
        spin_q       <= spin_d;
        base_q       <= base_d;
        total_q      <= total_d;
        sidx_q       <= sidx_d;
        widx_q       <= widx_d;
        last_block_q <= last_block_d;
        ok_q         <= ok_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= req_type_i;
      lba_q <= start_lba_i;
      cnt_q <= count_i;
      st_q  <= status_byte_i;
      dw_q  <= data_word_i;
    end
  end

  a_active_has_sectors : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PhIdle |-> total_q != 8'd0)
    else $error("active read with zero sector count");

  a_sector_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhWaitDrq || phase_q == PhData) |-> sidx_q < total_q)
    else $error("sector index beyond sector count");

  a_ok_only_on_success : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ok_q) |-> $past(phase_q) == PhData && phase_q == PhIdle)
    else $error("read ok flag set outside a completed read");

endmodule

[rtl/apls_emit.sv]
`timescale 1ns / 1ps
// Result register: holds one burst descriptor and hands out its results in order.
// Depends on apls_pkg; loaded by apls_ctrl.
module apls_emit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  apls_pkg::burst_t burst_i,
  output logic             emit_free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       out_kind_o,
  output logic [9:0]       port_o,
  output logic [15:0]      value_o,
  output logic [15:0]      word_index_o,
  output logic             read_ok_o,
  output logic [1:0]       fail_code_o,
  output logic [28:0]      last_block_o,
  output logic             is_last_o
);

  logic             valid_q;
  logic [3:0]       idx_q;
  apls_pkg::burst_t burst_q;
  apls_pkg::res_t   res;
  logic             at_last;

  assign at_last = idx_q == burst_q.last_idx;

  always_comb begin
    if (burst_q.cmd) begin
      res = apls_pkg::cmd_result(idx_q, burst_q.lba, burst_q.cnt);
    end else if (idx_q == 4'd0) begin
      res = burst_q.r0;
    end else begin
      res = burst_q.r1;
    end
  end

  assign emit_free_o  = !valid_q || (out_ready_i && at_last);
  assign out_valid_o  = valid_q;
  assign out_kind_o   = res.kind;
  assign port_o       = res.port;
  assign value_o      = res.value;
  assign word_index_o = res.word_index;
  assign read_ok_o    = res.read_ok;
  assign fail_code_o  = res.fail_code;
  assign last_block_o = burst_q.last_block;
  assign is_last_o    = at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 4'd0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= 4'd0;
    end else if (valid_q && out_ready_i) begin
      if (at_last) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

  a_idx_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> idx_q <= burst_q.last_idx)
    else $error("result index past end of burst");

  a_short_burst : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !burst_q.cmd |-> burst_q.last_idx <= 4'd1)
    else $error("non-command burst longer than two results");

  a_load_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> emit_free_o)
    else $error("burst loaded over pending results");

endmodule
